/* hw/rtl/tiaf_pkg.sv */
// Shared types and constants for the telnet IAC filter.
package tiaf_pkg;

    localparam logic [7:0] CODE_IAC  = 8'hFF;
    localparam logic [7:0] CODE_WILL = 8'hFB;
    localparam logic [7:0] CODE_WONT = 8'hFC;
    localparam logic [7:0] CODE_DO   = 8'hFD;
    localparam logic [7:0] CODE_DONT = 8'hFE;

    localparam logic DEST_USER   = 1'b0;
    localparam logic DEST_SERVER = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PS_NORMAL = 2'd0,
        PS_IAC    = 2'd1,
        PS_VERB   = 2'd2
    } tiaf_parse_t;

    typedef enum logic [1:0] {
        RS_IAC  = 2'd0,
        RS_VERB = 2'd1,
        RS_OPT  = 2'd2
    } tiaf_reply_step_t;

    // One classified word in the queue: either a byte for the user side or a
    // refusal to be sent back as three words.
    typedef struct packed {
        logic       is_reply;
        logic       reply_wont;
        logic [7:0] data;
        logic       block_end;
    } tiaf_entry_t;

    // Queue handshake seen by the back end.
    typedef struct packed {
        logic        avail;
        tiaf_entry_t entry;
    } tiaf_head_t;

endpackage

/* hw/rtl/tiaf_if.sv */
// Channel interfaces of the telnet IAC filter.
interface tiaf_rx_if;
    import tiaf_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       block_end_in;

    modport source (output valid, output rx_byte, output block_end_in, input ready);
    modport sink (input valid, input rx_byte, input block_end_in, output ready);
endinterface

interface tiaf_res_if;
    logic       valid;
    logic       ready;
    logic       out_dest;
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_end;

    modport source (output valid, output out_dest, output out_byte, output run_last,
                    output block_end, input ready);
    modport sink (input valid, input out_dest, input out_byte, input run_last,
                  input block_end, output ready);
endinterface

interface tiaf_cfg_if;
    logic valid;
    logic ready;
    logic filter_enable;

    modport source (output valid, output filter_enable, input ready);
    modport sink (input valid, input filter_enable, output ready);
endinterface

/* hw/rtl/tiaf_front.sv */
// Front end: accepts received bytes, tracks the IAC parser and classifies words.
module tiaf_front
    import tiaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tiaf_rx_if.sink           rx,
    tiaf_cfg_if.sink          cfg,
    input  logic              queue_full,
    output logic              push,
    output tiaf_entry_t       push_entry
);

    tiaf_parse_t parse_state_reg;
    tiaf_parse_t parse_state_next;
    logic [1:0]  pending_verb_reg;
    logic [1:0]  pending_verb_next;
    logic        filter_enable_reg;
    logic        accept;
    logic        is_verb;

    assign rx.ready  = !queue_full;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;
    assign is_verb   = (rx.rx_byte >= CODE_WILL) && (rx.rx_byte <= CODE_DONT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg   <= PS_NORMAL;
            pending_verb_reg  <= 2'd0;
            filter_enable_reg <= 1'b1;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                filter_enable_reg <= cfg.filter_enable;
            end
            if (accept)
            begin
                parse_state_reg  <= parse_state_next;
                pending_verb_reg <= pending_verb_next;
            end
        end
    end

    // Next parser state.
    always_comb
    begin
        parse_state_next  = parse_state_reg;
        pending_verb_next = pending_verb_reg;
        if (filter_enable_reg)
        begin
            case (parse_state_reg)
                PS_IAC:
                begin
                    if (rx.rx_byte == CODE_IAC)
                    begin
                        parse_state_next = PS_NORMAL;
                    end
                    else if (is_verb)
                    begin
                        // WILL..DONT map to 0..3 by adding one to the low bits.
                        pending_verb_next = rx.rx_byte[1:0] + 2'd1;
                        parse_state_next  = PS_VERB;
                    end
                    else
                    begin
                        parse_state_next = PS_NORMAL;
                    end
                end
                PS_VERB:
                begin
                    parse_state_next = PS_NORMAL;
                end
                default:
                begin
                    parse_state_next = (rx.rx_byte == CODE_IAC) ? PS_IAC : PS_NORMAL;
                end
            endcase
        end
    end

    // Classification of the word into the queue.
    always_comb
    begin
        push                  = 1'b0;
        push_entry.is_reply   = 1'b0;
        push_entry.reply_wont = pending_verb_reg[1];
        push_entry.data       = rx.rx_byte;
        push_entry.block_end  = rx.block_end_in;
        if (!filter_enable_reg)
        begin
            push = accept;
        end
        else
        begin
            case (parse_state_reg)
                PS_IAC:
                begin
                    push = accept && (rx.rx_byte == CODE_IAC);
                end
                PS_VERB:
                begin
                    push                = accept;
                    push_entry.is_reply = 1'b1;
                end
                default:
                begin
                    push = accept && (rx.rx_byte != CODE_IAC);
                end
            endcase
        end
    end

endmodule

/* hw/rtl/tiaf_queue.sv */
// Short queue of classified words between the front and back ends.
module tiaf_queue
    import tiaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tiaf_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output tiaf_head_t  head
);

    tiaf_entry_t                 store_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]         wr_ptr_reg;
    logic [QUEUE_AW-1:0]         rd_ptr_reg;
    logic [QUEUE_CW-1:0]         count_reg;
    logic [QUEUE_CW-1:0]         count_next;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head.avail = (count_reg != '0);
    assign head.entry = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/tiaf_back.sv */
// Back end: expands queued words into results and holds the output register.
module tiaf_back
    import tiaf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  tiaf_head_t    head,
    output logic          pop,
    tiaf_res_if.source    res
);

    tiaf_reply_step_t step_reg;
    tiaf_reply_step_t step_next;
    logic             load;
    logic             out_valid_reg;
    logic             out_dest_reg;
    logic [7:0]       out_byte_reg;
    logic             run_last_reg;
    logic             block_end_reg;
    logic             out_dest_next;
    logic [7:0]       out_byte_next;
    logic             run_last_next;
    logic             block_end_next;

    assign load = head.avail && (!out_valid_reg || res.ready);

    // Step through a refusal triple; plain words take one step.
    always_comb
    begin
        step_next = step_reg;
        if (load && head.entry.is_reply)
        begin
            case (step_reg)
                RS_IAC:  step_next = RS_VERB;
                RS_VERB: step_next = RS_OPT;
                default: step_next = RS_IAC;
            endcase
        end
    end

    // Result word for the current step.
    always_comb
    begin
        out_dest_next  = DEST_USER;
        out_byte_next  = head.entry.data;
        run_last_next  = 1'b1;
        block_end_next = head.entry.block_end;
        pop            = load;
        if (head.entry.is_reply)
        begin
            out_dest_next = DEST_SERVER;
            case (step_reg)
                RS_IAC:
                begin
                    out_byte_next  = CODE_IAC;
                    run_last_next  = 1'b0;
                    block_end_next = 1'b0;
                    pop            = 1'b0;
                end
                RS_VERB:
                begin
                    out_byte_next  = head.entry.reply_wont ? CODE_WONT : CODE_DONT;
                    run_last_next  = 1'b0;
                    block_end_next = 1'b0;
                    pop            = 1'b0;
                end
                default:
                begin
                    pop = load;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= RS_IAC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_dest_reg  <= out_dest_next;
            out_byte_reg  <= out_byte_next;
            run_last_reg  <= run_last_next;
            block_end_reg <= block_end_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_dest  = out_dest_reg;
    assign res.out_byte  = out_byte_reg;
    assign res.run_last  = run_last_reg;
    assign res.block_end = block_end_reg;

endmodule

/* hw/rtl/telnet_iac_filter.sv */
// Top level of the telnet IAC filter.
//
// The rx channel takes one byte received from the server per word, with a
// flag on the last byte of each block. The res channel gives the resulting
// words: user-side bytes, and refusal triples (IAC, DONT or WONT, option)
// addressed back to the server. run_last marks the final word caused by an
// input byte and carries the block flag on it. The cfg channel writes
// filter_enable; it is always ready and is meant to be written while idle.
// An input word is taken every cycle while the four-entry queue has room.
// A result passes through the queue and then the output register after its
// byte is accepted. The back end emits one word per cycle while the receiver
// is ready, one for a plain byte and three for a refusal; the queue absorbs
// short bursts of these. A receiver stall holds the output register and
// fills the queue, after which rx.ready falls. Reset empties the queue, drops
// any pending output, returns the parser to its normal state and switches
// filtering on.
module telnet_iac_filter
    import tiaf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tiaf_rx_if.sink      rx,
    tiaf_cfg_if.sink     cfg,
    tiaf_res_if.source   res
);

    logic        queue_full;
    logic        push;
    tiaf_entry_t push_entry;
    logic        pop;
    tiaf_head_t  head;

    // Parser and classifier; holds the filter enable register.
    tiaf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouples the parser from refusal expansion and output stalls.
    tiaf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head)
    );

    // Expands each queued word and drives the registered output.
    tiaf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

/* dv/tb_telnet_iac_filter.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the telnet IAC filter: directed table, then random telnet traffic.
module tb_telnet_iac_filter;
    import tiaf_pkg::*;

    // One word on the result channel, as the checker sees it.
    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       last;
        logic       blk;
    } res_word_t;

    // A directed row either sends a byte whose results come from the predictor,
    // sends a byte whose results are typed into the row, or writes filter_enable.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_TYPED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] data;      // received byte, or the register value in a ROW_CFG row
        logic       blk;
        logic [1:0] n_words;   // typed rows only: zero or one word
        res_word_t  word;
    } row_t;

    typedef struct packed {
        logic enable;
        int   n_items;
    } phase_t;

    localparam int        CLK_HALF     = 2;
    localparam int        RESET_CYCLES = 5;
    // Results pass through the queue and then the output register; this wait leaves ample margin for
    // bytes that cause no word but may still be in flight inside the block.
    localparam int        SETTLE_CYCLES = 10;
    localparam int        HOLD_CYCLES   = 80;
    localparam int        PRESSURE_ITEMS = 40;
    localparam int        CYCLE_LIMIT    = 200000;
    localparam res_word_t NO_WORD = '0;

    // Directed part. Typed rows carry results that are obvious by inspection;
    // the refusal rows are left to the predictor.
    localparam row_t DIR_TAB [31] = '{
        // Plain bytes at the low end and around the 7-bit boundary, block flag both ways.
        '{ROW_TYPED, 8'h00, 1'b0, 2'd1, '{DEST_USER, 8'h00, 1'b1, 1'b0}},
        '{ROW_TYPED, 8'h7F, 1'b1, 2'd1, '{DEST_USER, 8'h7F, 1'b1, 1'b1}},
        '{ROW_TYPED, 8'h80, 1'b0, 2'd1, '{DEST_USER, 8'h80, 1'b1, 1'b0}},
        // A verb code outside a command is just data.
        '{ROW_TYPED, CODE_WILL, 1'b0, 2'd1, '{DEST_USER, CODE_WILL, 1'b1, 1'b0}},
        // An opening IAC produces nothing, so its block flag is lost.
        '{ROW_TYPED, CODE_IAC, 1'b1, 2'd0, NO_WORD},
        // The doubled IAC gives one literal 0xFF to the user side.
        '{ROW_TYPED, CODE_IAC, 1'b1, 2'd1, '{DEST_USER, CODE_IAC, 1'b1, 1'b1}},
        // Each of the four verbs, answered with a refusal triple.
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_WILL, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, 8'h01, 1'b1, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_WONT, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, 8'h00, 1'b0, 2'd0, NO_WORD},
        // Verb at the end of a block: the parser state carries into the next.
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_DO, 1'b1, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_DONT, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, 8'h18, 1'b1, 2'd0, NO_WORD},
        // Lone commands, subnegotiation markers among them, are dropped.
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_TYPED, 8'hF1, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_TYPED, 8'hFA, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_TYPED, 8'hF0, 1'b1, 2'd0, NO_WORD},
        // IAC pending when filtering is switched off: bytes pass untouched,
        // and the parser picks up where it left off once filtering resumes.
        '{ROW_BYTE, CODE_IAC, 1'b0, 2'd0, NO_WORD},
        '{ROW_CFG, 8'h00, 1'b0, 2'd0, NO_WORD},
        '{ROW_TYPED, CODE_IAC, 1'b1, 2'd1, '{DEST_USER, CODE_IAC, 1'b1, 1'b1}},
        '{ROW_TYPED, CODE_DO, 1'b0, 2'd1, '{DEST_USER, CODE_DO, 1'b1, 1'b0}},
        '{ROW_CFG, 8'h01, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, CODE_WILL, 1'b0, 2'd0, NO_WORD},
        '{ROW_BYTE, 8'h05, 1'b1, 2'd0, NO_WORD}
    };

    // Random phases after the pressure test, alternating the filter setting.
    localparam phase_t PHASES [4] = '{
        '{1'b0, 40},
        '{1'b1, 100},
        '{1'b0, 30},
        '{1'b1, 80}
    };

    logic clk;
    logic rst_n;

    tiaf_rx_if  rx_ch ();
    tiaf_cfg_if cfg_ch ();
    tiaf_res_if res_ch ();

    telnet_iac_filter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .cfg   (cfg_ch),
        .res   (res_ch)
    );

    // Predictor state: the filter setting and the command parser.
    logic        filter_on;
    tiaf_parse_t parse_st;
    logic [1:0]  verb_code;     // verb seen, as its code minus WILL

    res_word_t   next_words [3];
    res_word_t   pending_words [$];

    int unsigned n_errors;
    int unsigned items_sent;
    int unsigned burst_left;
    logic        gapless;
    int unsigned hold_asks;

    initial begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Works out the words that one accepted byte gives and leaves them in
    // next_words; returns how many there are.
    function automatic int filter_byte(input logic [7:0] b, input logic blk);
        logic [7:0] reply;
        if (!filter_on) begin
            next_words[0] = '{DEST_USER, b, 1'b1, blk};
            return 1;
        end
        case (parse_st)
            PS_IAC: begin
                if (b == CODE_IAC) begin
                    parse_st      = PS_NORMAL;
                    next_words[0] = '{DEST_USER, CODE_IAC, 1'b1, blk};
                    return 1;
                end
                if (b >= CODE_WILL && b <= CODE_DONT) begin
                    verb_code = 2'(b - CODE_WILL);
                    parse_st  = PS_VERB;
                    return 0;
                end
                parse_st = PS_NORMAL;
                return 0;
            end
            PS_VERB: begin
                // WILL and WONT are refused with DONT, DO and DONT with WONT.
                reply         = verb_code[1] ? CODE_WONT : CODE_DONT;
                next_words[0] = '{DEST_SERVER, CODE_IAC, 1'b0, 1'b0};
                next_words[1] = '{DEST_SERVER, reply, 1'b0, 1'b0};
                next_words[2] = '{DEST_SERVER, b, 1'b1, blk};
                parse_st      = PS_NORMAL;
                return 3;
            end
            default: begin
                parse_st = PS_NORMAL;
                if (b == CODE_IAC) begin
                    parse_st = PS_IAC;
                    return 0;
                end
                next_words[0] = '{DEST_USER, b, 1'b1, blk};
                return 1;
            end
        endcase
    endfunction

    function automatic logic rand_blk();
        return $urandom_range(0, 7) == 0;
    endfunction

    // Offers one byte and waits for it to be taken. The sender runs in bursts
    // of random length with random gaps in between, unless gapless is set.
    // valid is left high after acceptance so that back-to-back words do not
    // lower and raise it in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic blk,
                             input logic typed = 1'b0, input int n_typed = 0,
                             input res_word_t typed_word = '0);
        int unsigned gap;
        int          n;
        if (!gapless && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        rx_ch.valid        <= 1'b1;
        rx_ch.rx_byte      <= b;
        rx_ch.block_end_in <= blk;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        items_sent++;
        n = filter_byte(b, blk);
        if (typed) begin
            n             = n_typed;
            next_words[0] = typed_word;
        end
        for (int k = 0; k < n; k++) begin
            pending_words.push_back(next_words[k]);
        end
    endtask

    // Stops offering and waits until every expected word has arrived, then a
    // little longer for bytes that leave no word behind.
    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_filter(input logic en);
        drain();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.filter_enable <= en;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        filter_on = en;
    endtask

    // One piece of telnet traffic. Most are well-formed sequences with random
    // content; the rest are stray bytes and sequences cut short, which leave
    // the parser mid-command for whatever follows.
    task automatic send_segment();
        int unsigned pick;
        logic [7:0]  verb;
        pick = $urandom_range(0, 9);
        verb = 8'($urandom_range(CODE_WILL, CODE_DONT));
        case (pick)
            0, 1, 2, 3: begin
                send_byte(8'($urandom_range(0, CODE_IAC - 1)), rand_blk());
            end
            4: begin
                send_byte(CODE_IAC, rand_blk());
                send_byte(CODE_IAC, rand_blk());
            end
            5: begin
                send_byte(CODE_IAC, rand_blk());
                send_byte(8'($urandom_range(0, CODE_WILL - 1)), rand_blk());
            end
            6, 7: begin
                send_byte(CODE_IAC, rand_blk());
                send_byte(verb, rand_blk());
                send_byte(8'($urandom_range(0, 255)), rand_blk());
            end
            8: begin
                send_byte(CODE_IAC, rand_blk());
                if ($urandom_range(0, 1) == 1) begin
                    send_byte(verb, rand_blk());
                end
            end
            default: begin
                send_byte(8'($urandom_range(0, 255)), rand_blk());
            end
        endcase
    endtask

    // Receiver: checks each word taken against the oldest expectation and
    // drives ready from a stall pattern of its own, which is redrawn at random
    // and is sometimes all ones. A hold request from the stimulus side makes it
    // refuse words while a hold counter, loaded from HOLD_CYCLES, runs down here.
    initial begin
        int unsigned cyc;
        int unsigned hold_left;
        int unsigned hold_taken;
        logic [31:0] stall_pat;
        res_word_t   got;
        res_word_t   want;
        cyc        = 0;
        hold_left  = 0;
        hold_taken = 0;
        stall_pat  = '1;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                got = '{res_ch.out_dest, res_ch.out_byte, res_ch.run_last, res_ch.block_end};
                if (pending_words.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected word dest=%0d byte=%02h last=%0d blk=%0d",
                             $time, got.dest, got.data, got.last, got.blk);
                end
                else begin
                    want = pending_words.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        // Words are shown as dest, byte, last, blk.
                        $display("%0t: mismatch, expected %0d %02h %0d %0d, got %0d %02h %0d %0d",
                                 $time, want.dest, want.data, want.last, want.blk,
                                 got.dest, got.data, got.last, got.blk);
                    end
                end
            end
            cyc++;
            if (hold_asks != hold_taken) begin
                hold_taken = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (cyc % 64 == 0) begin
                stall_pat = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else begin
                res_ch.ready <= stall_pat[cyc % 32];
            end
        end
    end

    // Watchdog on a cycle count, well beyond the slowest correct run.
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d words outstanding",
                 $time, cycle_count, pending_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus: reset, the directed table, a back-pressure run, then random
    // traffic in phases with filtering alternately off and on.
    initial begin
        n_errors   = 0;
        items_sent = 0;
        burst_left = 0;
        gapless    = 1'b0;
        hold_asks  = 0;
        filter_on  = 1'b1;
        parse_st   = PS_NORMAL;
        verb_code  = 2'd0;
        rst_n                <= 1'b0;
        rx_ch.valid          <= 1'b0;
        rx_ch.rx_byte        <= 8'h00;
        rx_ch.block_end_in   <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.filter_enable <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TAB[i]) begin
            if (DIR_TAB[i].kind == ROW_CFG) begin
                set_filter(DIR_TAB[i].data[0]);
            end
            else begin
                send_byte(DIR_TAB[i].data, DIR_TAB[i].blk, DIR_TAB[i].kind == ROW_TYPED,
                          int'(DIR_TAB[i].n_words), DIR_TAB[i].word);
            end
        end

        // The receiver holds off while the sender keeps offering words without
        // a gap, so the queue fills and the input stalls. The sender then
        // pauses until every expected word has come out.
        set_filter(1'b1);
        hold_asks++;
        gapless = 1'b1;
        for (int k = 0; k < PRESSURE_ITEMS; k++) begin
            send_segment();
        end
        gapless = 1'b0;
        drain();

        foreach (PHASES[p]) begin
            int unsigned target;
            set_filter(PHASES[p].enable);
            target = items_sent + PHASES[p].n_items;
            while (items_sent < target) begin
                send_segment();
            end
        end

        drain();
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
